// File: src/grne_pkg.sv
// ----------------------------------------------------------------------------
// grne_pkg
// shared widths, codes and controller/datapath interface types for the
// ring neighbour enumerator
// ----------------------------------------------------------------------------
package grne_pkg;

    // field widths
    localparam int IDX_W      = 17;
    localparam int GRID_W     = 9;
    localparam int RAD_W      = 3;
    localparam int TDATA_W    = 24;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_SIZE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_RADIUS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INCLUDE_CENTER = 2'd2;

    localparam logic [GRID_W-1:0] GRID_SIZE_RST      = 9'd16;
    localparam logic [RAD_W-1:0]  RING_RADIUS_RST    = 3'd1;
    localparam logic              INCLUDE_CENTER_RST = 1'b1;

    // default top level parameters
    localparam int MAX_GRID_SIZE_DEF = 256;
    localparam int MAX_RADIUS_DEF    = 7;

    // divider: dividend padded to an even width, two quotient bits per cycle
    localparam int DIV_W     = 18;
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    // which group of ring cells the datapath evaluates
    typedef enum logic [1:0] {
        PH_CENTER,
        PH_AXIS,
        PH_HRING,
        PH_VRING
    } t_phase;

    typedef struct packed {
        logic             load;
        logic             div_en;
        t_phase           phase;
        logic [RAD_W-1:0] k;
        logic [1:0]       sub;
        logic             take;
        logic             push;
        logic             last;
    } t_ctl_cmd;

    typedef struct packed {
        logic             cand_ok;
        logic             pend_valid;
        logic             out_free;
        logic             item_bad;
        logic [RAD_W-1:0] r_eff;
    } t_dp_status;

endpackage

// File: src/grne_ctrl.sv
// ----------------------------------------------------------------------------
// grne_ctrl
// sequencer: divide, then, in grid, walk center, axis, horizontal and vertical
// ring cells one candidate per unstalled cycle, then flush held result as last
// ----------------------------------------------------------------------------
module grne_ctrl
    import grne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CENTER,
        S_AXIS,
        S_HRING,
        S_VRING,
        S_FLUSH
    } t_state;

    t_state               r_state;
    logic [RAD_W-1:0]     r_k;
    logic [1:0]           r_sub;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic   enum_st;
    logic   stall;
    t_phase phase;

    assign enum_st = (r_state == S_CENTER) || (r_state == S_AXIS) ||
                     (r_state == S_HRING) || (r_state == S_VRING);
    assign stall   = i_status.cand_ok && i_status.pend_valid && !i_status.out_free;

    always_comb begin
        unique case (r_state)
            S_AXIS:  phase = PH_AXIS;
            S_HRING: phase = PH_HRING;
            S_VRING: phase = PH_VRING;
            default: phase = PH_CENTER;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_en = (r_state == S_DIV);
        o_cmd.phase  = phase;
        o_cmd.k      = r_k;
        o_cmd.sub    = r_sub;
        o_cmd.take   = enum_st && i_status.cand_ok && !stall;
        o_cmd.push   = (enum_st && i_status.cand_ok && i_status.pend_valid &&
                        i_status.out_free) ||
                       ((r_state == S_FLUSH) && i_status.pend_valid && i_status.out_free);
        o_cmd.last   = (r_state == S_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_sub   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
                        r_state <= i_status.item_bad ? S_IDLE : S_CENTER;
                    end
                end
                S_CENTER: begin
                    if (!stall) begin
                        r_sub   <= '0;
                        r_state <= (i_status.r_eff == '0) ? S_FLUSH : S_AXIS;
                    end
                end
                S_AXIS: begin
                    if (!stall) begin
                        r_sub <= r_sub + 1'b1;
                        if (r_sub == 2'd3) begin
                            r_k     <= RAD_W'(1);
                            r_state <= (i_status.r_eff >= RAD_W'(2)) ? S_HRING : S_VRING;
                        end
                    end
                end
                S_HRING: begin
                    if (!stall) begin
                        r_sub <= r_sub + 1'b1;
                        if (r_sub == 2'd3) begin
                            if (r_k == RAD_W'(i_status.r_eff - RAD_W'(1))) begin
                                r_k     <= RAD_W'(1);
                                r_state <= S_VRING;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                    end
                end
                S_VRING: begin
                    if (!stall) begin
                        r_sub <= r_sub + 1'b1;
                        if (r_sub == 2'd3) begin
                            if (r_k == i_status.r_eff) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (!i_status.pend_valid || i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a push never lands on an occupied output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_status.out_free)
        else $error("push while output register busy");

    // no held result survives into the idle state
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_status.pend_valid)
        else $error("held result left behind at end of run");

    // a flush that pushes its held result returns the sequencer to idle
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && i_status.pend_valid && i_status.out_free)
        |=> (r_state == S_IDLE))
        else $error("flush did not finish the run");

    // candidates are only taken while walking the ring
    a_take_enum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> enum_st)
        else $error("candidate taken outside ring walk");

endmodule

// File: src/grne_datapath.sv
// ----------------------------------------------------------------------------
// grne_datapath
// operand registers, radix-4 restoring divider for row/column, candidate
// index and bounds check, held result and output register
// ----------------------------------------------------------------------------
module grne_datapath
    import grne_pkg::*;
#(
    parameter int MAX_GRID_SIZE = MAX_GRID_SIZE_DEF,
    parameter int MAX_RADIUS    = MAX_RADIUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl_cmd          i_cmd,
    output t_dp_status        o_status,
    input  logic [GRID_W-1:0] i_grid_size,
    input  logic [RAD_W-1:0]  i_ring_radius,
    input  logic              i_include_center,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_out_idx,
    output logic              o_out_center,
    output logic              o_out_last
);

    // grid side width after clamping
    localparam int NW_RAW = $clog2(MAX_GRID_SIZE + 1);
    localparam int NW     = (NW_RAW < GRID_W) ? NW_RAW : GRID_W;
    localparam int PW     = RAD_W + NW;

    logic [IDX_W-1:0]  r_a;
    logic [NW-1:0]     r_n;
    logic [2*NW-1:0]   r_nn;
    logic [RAD_W-1:0]  r_r;
    logic              r_ctr;
    logic [DIV_W-1:0]  r_dq;
    logic [NW-1:0]     r_rem;
    logic              r_pend_valid;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_pend_ctr;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_ctr;
    logic              r_out_last;

    logic [NW-1:0]     n_eff;
    logic [RAD_W-1:0]  rad_eff;
    logic [DIV_W-1:0]  n_dq;
    logic [NW-1:0]     n_rem;

    // clamp configuration at load
    always_comb begin
        if (32'(i_grid_size) > MAX_GRID_SIZE) begin
            n_eff = NW'(MAX_GRID_SIZE);
        end else begin
            n_eff = NW'(i_grid_size);
        end
        if (32'(i_ring_radius) > MAX_RADIUS) begin
            rad_eff = RAD_W'(MAX_RADIUS);
        end else begin
            rad_eff = i_ring_radius;
        end
    end

    // two restoring divide steps per cycle
    always_comb begin
        logic [NW:0]      trial;
        logic [DIV_W-1:0] dq;
        logic [NW-1:0]    rem;
        dq  = r_dq;
        rem = r_rem;
        for (int s = 0; s < DIV_STEPS; s++) begin
            trial = {rem, dq[DIV_W-1]};
            dq    = {dq[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_n}) begin
                trial = trial - {1'b0, r_n};
                dq[0] = 1'b1;
            end
            rem = trial[NW-1:0];
        end
        n_dq  = dq;
        n_rem = rem;
    end

    // distances to the four grid edges
    logic [NW-1:0] up, down, left, right;
    assign up    = r_rem;
    assign left  = r_dq[NW-1:0];
    assign down  = r_n - NW'(1) - up;
    assign right = r_n - NW'(1) - left;

    // candidate offset decode
    logic             c_neg, w_neg, is_c;
    logic [RAD_W-1:0] c_mag, w_mag;
    always_comb begin
        c_neg = 1'b0;
        w_neg = 1'b0;
        c_mag = '0;
        w_mag = '0;
        is_c  = 1'b0;
        unique case (i_cmd.phase)
            PH_CENTER: begin
                is_c = 1'b1;
            end
            PH_AXIS: begin
                case (i_cmd.sub)
                    2'd0: begin
                        w_neg = 1'b1;
                        w_mag = r_r;
                    end
                    2'd1: w_mag = r_r;
                    2'd2: begin
                        c_neg = 1'b1;
                        c_mag = r_r;
                    end
                    default: c_mag = r_r;
                endcase
            end
            PH_HRING: begin
                c_mag = i_cmd.k;
                c_neg = !i_cmd.sub[1];
                w_mag = r_r;
                w_neg = !i_cmd.sub[0];
            end
            PH_VRING: begin
                c_mag = r_r;
                c_neg = !i_cmd.sub[1];
                w_mag = i_cmd.k;
                w_neg = !i_cmd.sub[0];
            end
            default: is_c = 1'b1;
        endcase
    end

    logic             col_ok, row_ok, cand_ok;
    logic [PW-1:0]    prod;
    logic [IDX_W-1:0] col_off, row_off, cand_idx;

    assign col_ok  = c_neg ? (32'(left) >= 32'(c_mag)) : (32'(right) >= 32'(c_mag));
    assign row_ok  = w_neg ? (32'(up) >= 32'(w_mag)) : (32'(down) >= 32'(w_mag));
    assign cand_ok = is_c ? r_ctr : (col_ok && row_ok);

    // index arithmetic wraps at the field width, as the result field does
    assign prod     = PW'(c_mag) * PW'(r_n);
    assign col_off  = c_neg ? (IDX_W'(0) - IDX_W'(prod)) : IDX_W'(prod);
    assign row_off  = w_neg ? (IDX_W'(0) - IDX_W'(w_mag)) : IDX_W'(w_mag);
    assign cand_idx = r_a + col_off + row_off;

    always_comb begin
        o_status            = '0;
        o_status.cand_ok    = cand_ok;
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.item_bad   = (r_n == '0) || (r_a == '0) || (32'(r_a) > 32'(r_nn));
        o_status.r_eff      = r_r;
    end

    // operands and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_cell_index;
            r_n   <= n_eff;
            r_nn  <= (2*NW)'(n_eff) * (2*NW)'(n_eff);
            r_r   <= rad_eff;
            r_ctr <= i_include_center;
            r_dq  <= {1'b0, i_cell_index - IDX_W'(1)};
            r_rem <= '0;
        end else if (i_cmd.div_en) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
        end
    end

    // held result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_idx <= cand_idx;
            r_pend_ctr <= is_c;
        end
        if (i_cmd.push) begin
            r_out_idx  <= r_pend_idx;
            r_out_ctr  <= r_pend_ctr;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_idx    = r_out_idx;
    assign o_out_center = r_out_ctr;
    assign o_out_last   = r_out_last;

endmodule

// File: src/grid_ring_neighbour_enumerator_core.sv
// ----------------------------------------------------------------------------
// grid_ring_neighbour_enumerator_core
// enumerates the center and the chebyshev ring cells of one grid cell
// ----------------------------------------------------------------------------
// first beat: the input beat is loaded, divided, and the center candidate is
//   held until the next cell is taken or the run flushes, then registered out
// a new input beat is accepted only once the previous run has ended, and the
//   sequencer checks one candidate cell per cycle while the output does not
//   stall; out-of-grid items end after the divide with no beats
// reset: synchronous active low, loads grid 16, radius 1, center on

module grid_ring_neighbour_enumerator_core
    import grne_pkg::*;
#(
    parameter int MAX_GRID_SIZE = MAX_GRID_SIZE_DEF,
    parameter int MAX_RADIUS    = MAX_RADIUS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // [16:0] cell_index, rest zero

    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // [16:0] neighbour_index, rest zero
    output logic                  m_axis_tuser,   // [0] is_center
    output logic                  m_axis_tlast    // last_of_run
);

    // configuration registers; the user writes them only while the block is idle, the block does not enforce it
    logic [GRID_W-1:0] r_grid_size;
    logic [RAD_W-1:0]  r_ring_radius;
    logic              r_include_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size      <= GRID_SIZE_RST;
            r_ring_radius    <= RING_RADIUS_RST;
            r_include_center <= INCLUDE_CENTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID_SIZE:      r_grid_size      <= i_cfg_data[GRID_W-1:0];
                CFG_RING_RADIUS:    r_ring_radius    <= i_cfg_data[RAD_W-1:0];
                CFG_INCLUDE_CENTER: r_include_center <= i_cfg_data[0];
                default: ;  // unknown index is dropped
            endcase
        end
    end

    t_ctl_cmd         cmd;
    t_dp_status       status;
    logic [IDX_W-1:0] out_idx;

    // controller: owns the state, the ring counters and the divide count
    grne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: divider, candidate arithmetic, one held result plus the
    // output register so the last flag is known before a beat goes out
    grne_datapath #(
        .MAX_GRID_SIZE (MAX_GRID_SIZE),
        .MAX_RADIUS    (MAX_RADIUS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_grid_size      (r_grid_size),
        .i_ring_radius    (r_ring_radius),
        .i_include_center (r_include_center),
        .i_cell_index     (s_axis_tdata[IDX_W-1:0]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_out_idx        (out_idx),
        .o_out_center     (m_axis_tuser),
        .o_out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'(out_idx);

endmodule

// File: tb/tb_grid_ring_neighbour_enumerator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_ring_neighbour_enumerator_core
// self-checking bench for the chebyshev ring neighbor enumerator: a local
// predictor lists the center and ring cells of every accepted input beat,
// and each result beat is compared in order; directed corner cases come
// first, then random grids, radii and cells under random stalls on both sides
// ----------------------------------------------------------------------------

module tb_grid_ring_neighbour_enumerator_core;
    import grne_pkg::*;

    localparam int TB_MAX_GRID   = MAX_GRID_SIZE_DEF;
    localparam int TB_MAX_RADIUS = MAX_RADIUS_DEF;
    localparam int PAD_W         = TDATA_W - IDX_W;
    localparam int CYCLE_LIMIT   = 1500000;
    // an out-of-grid beat occupies the block through the divide with nothing to show
    localparam int DRAIN_CYCLES  = 48;
    localparam int MAX_REPORTS   = 10;

    // index past the register list, writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] nbr;
        logic             center;
        logic             last;
    } t_ring_beat;

    // dut signals
    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata   = '0;   // [16:0] cell_index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;          // [16:0] neighbour_index
    logic                  m_axis_tuser;          // [0] is_center
    logic                  m_axis_tlast;

    // register mirror, reset values of the block
    logic [GRID_W-1:0]     grid_mirror   = GRID_SIZE_RST;
    logic [RAD_W-1:0]      radius_mirror = RING_RADIUS_RST;
    logic                  center_mirror = INCLUDE_CENTER_RST;

    t_ring_beat            ring_expected[$];
    t_ring_beat            ring_run[$];

    int                    tx_idle_pct   = 17;
    int                    rx_idle_pct   = 45;
    int                    rx_hold_req   = 0;
    int                    rx_hold_left  = 0;
    int                    cycle_cnt     = 0;
    int                    mismatches    = 0;
    int                    cells_in      = 0;
    int                    ring_beats    = 0;
    int                    settings_used = 1;

    grid_ring_neighbour_enumerator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ERROR: cycle limit of %0d reached, %0d beats still expected",
                     CYCLE_LIMIT, ring_expected.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: center first, then axis cells, then the horizontal edges of
    // the ring (column offsets below r), then the vertical edges
    // ------------------------------------------------------------------------
    function automatic void add_ring_cell(input int idx, input logic is_ctr);
        t_ring_beat beat;
        beat.nbr    = IDX_W'(idx);
        beat.center = is_ctr;
        beat.last   = 1'b0;
        ring_run.insert(ring_run.size(), beat);
    endfunction

    function automatic void ring_of_cell(input logic [IDX_W-1:0] cell_idx);
        t_ring_beat beat;
        int a, n, r, up, down, left, right, h, v;
        a = int'(cell_idx);
        n = int'(grid_mirror);
        r = int'(radius_mirror);
        ring_run.delete();
        // oversize registers saturate at the build limits
        if (n > TB_MAX_GRID) n = TB_MAX_GRID;
        if (r > TB_MAX_RADIUS) r = TB_MAX_RADIUS;
        // empty grid or index outside it: no beats at all
        if (n == 0 || a == 0 || a > n * n) return;
        up    = (a - 1) % n;
        down  = n - 1 - up;
        left  = (a - 1) / n;
        right = n - 1 - left;
        if (center_mirror) add_ring_cell(a, 1'b1);
        if (r > 0) begin
            if (up >= r)    add_ring_cell(a - r, 1'b0);
            if (down >= r)  add_ring_cell(a + r, 1'b0);
            if (left >= r)  add_ring_cell(a - r * n, 1'b0);
            if (right >= r) add_ring_cell(a + r * n, 1'b0);
            for (h = 1; h < r; h++) begin
                if (left >= h) begin
                    if (up >= r)   add_ring_cell(a - h * n - r, 1'b0);
                    if (down >= r) add_ring_cell(a - h * n + r, 1'b0);
                end
                if (right >= h) begin
                    if (up >= r)   add_ring_cell(a + h * n - r, 1'b0);
                    if (down >= r) add_ring_cell(a + h * n + r, 1'b0);
                end
            end
            for (v = 1; v <= r; v++) begin
                if (left >= r) begin
                    if (up >= v)   add_ring_cell(a - r * n - v, 1'b0);
                    if (down >= v) add_ring_cell(a - r * n + v, 1'b0);
                end
                if (right >= r) begin
                    if (up >= v)   add_ring_cell(a + r * n - v, 1'b0);
                    if (down >= v) add_ring_cell(a + r * n + v, 1'b0);
                end
            end
        end
        // tlast goes on the final beat of the run only
        foreach (ring_run[i]) begin
            beat      = ring_run[i];
            beat.last = (i == ring_run.size() - 1);
            ring_expected.insert(ring_expected.size(), beat);
        end
    endfunction

    // input monitor: every accepted beat feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            cells_in <= cells_in + 1;
            ring_of_cell(s_axis_tdata[IDX_W-1:0]);
        end
    end

    // result checker, in order against the oldest expectation
    always @(posedge i_clk) begin
        t_ring_beat want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            ring_beats <= ring_beats + 1;
            if (ring_expected.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected beat idx %0d center %0b last %0b",
                             m_axis_tdata[IDX_W-1:0], m_axis_tuser, m_axis_tlast);
            end else begin
                want = ring_expected.pop_front();
                if (m_axis_tdata !== {{PAD_W{1'b0}}, want.nbr} ||
                    m_axis_tuser !== want.center || m_axis_tlast !== want.last) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("ERROR: beat mismatch, expected idx %0d center %0b last %0b, ",
                               want.nbr, want.center, want.last);
                        $display("got tdata 0x%06h center %0b last %0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (rx_hold_req > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_req - 1;
            rx_hold_req    = 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------

    // one register write; we drops the following cycle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_GRID_SIZE:      grid_mirror   = data[GRID_W-1:0];
            CFG_RING_RADIUS:    radius_mirror = data[RAD_W-1:0];
            CFG_INCLUDE_CENTER: center_mirror = data[0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ring(input logic [CFG_DATA_W-1:0] grid,
                            input logic [CFG_DATA_W-1:0] radius,
                            input logic [CFG_DATA_W-1:0] center);
        write_reg(CFG_GRID_SIZE, grid);
        write_reg(CFG_RING_RADIUS, radius);
        write_reg(CFG_INCLUDE_CENTER, center);
        settings_used++;
    endtask

    // offers one cell beat, returns at the edge it is taken; tvalid stays up
    // so back-to-back beats need no drop in between
    task automatic send_cell(input logic [IDX_W-1:0] cell_idx);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, cell_idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering, wait out every expected beat, then the pipeline tail;
    // one edge first so the monitor has logged the last accepted beat
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ring_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset registers: 16x16 grid, radius 1, center on
    task automatic test_reset_defaults();
        send_cell(17'd1);        // top-left corner
        send_cell(17'd16);       // bottom of first column
        send_cell(17'd17);
        send_cell(17'd136);      // interior
        send_cell(17'd256);      // last cell of the grid
        send_cell(17'd257);      // just outside
        send_cell(17'd0);        // index zero
        send_cell(17'h1FFFF);    // all index bits set
        settle();
    endtask

    task automatic test_tiny_grids();
        // empty grid emits nothing
        set_ring(9'd0, 9'd1, 9'd1);
        send_cell(17'd1);
        send_cell(17'd5);
        settle();
        // single cell, center off: nothing qualifies
        set_ring(9'd1, 9'd1, 9'd0);
        send_cell(17'd1);
        settle();
        // single cell, center on: the center alone
        write_reg(CFG_INCLUDE_CENTER, 9'd1);
        send_cell(17'd1);
        send_cell(17'd2);
        settle();
    endtask

    task automatic test_radius_extremes();
        // oversize grid acts as the max, radius 7 from a data word with high bits
        set_ring(9'd511, 9'h1FF, 9'd1);
        send_cell(17'd65536);    // far corner, top index bit set
        send_cell(17'd32896);    // interior: full 57-beat ring
        send_cell(17'd1);
        settle();
        // radius 0 via masked data: center only
        write_reg(CFG_RING_RADIUS, 9'd8);
        send_cell(17'd100);
        send_cell(17'd300);
        settle();
        // a write past the register list changes nothing
        write_reg(CFG_UNMAPPED, 9'd0);
        write_reg(CFG_UNMAPPED, 9'h1FF);
        send_cell(17'd50);
        settle();
    endtask

    // receiver holds off long while the sender keeps offering, so the block
    // backs up and drops s_axis_tready
    task automatic test_output_backpressure();
        set_ring(9'd10, 9'd2, 9'd1);
        rx_hold_req = 400;
        repeat (16) send_cell(IDX_W'($urandom_range(1, 100)));
        settle();
    endtask

    // sender waits for every result before the next beat
    task automatic test_paused_sender();
        set_ring(9'd7, 9'd3, 9'd0);
        repeat (8) begin
            send_cell(IDX_W'($urandom_range(1, 49)));
            settle();
        end
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int n_settings, input int per_setting);
        logic [CFG_DATA_W-1:0] grid, radius;
        logic [IDX_W-1:0]      cell_idx;
        int                    roll, n_eff, in_grid;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_settings) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)       grid = 9'd0;
            else if (roll < 10) grid = CFG_DATA_W'($urandom_range(257, 511));
            else if (roll < 18) grid = 9'd256;
            else if (roll < 26) grid = CFG_DATA_W'($urandom_range(1, 3));
            else                grid = CFG_DATA_W'($urandom_range(4, 40));
            roll = $urandom_range(0, 99);
            if (roll < 6)       radius = 9'd0;
            else if (roll < 30) radius = CFG_DATA_W'($urandom_range(4, 7));
            else                radius = CFG_DATA_W'($urandom_range(1, 3));
            // unused high data bits are don't-care
            if ($urandom_range(0, 3) == 0) radius[8:3] = 6'($urandom_range(0, 63));
            set_ring(grid, radius, CFG_DATA_W'($urandom_range(0, 511)));
            if ($urandom_range(0, 99) < 15) begin
                write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 511)));
            end
            n_eff = (grid > TB_MAX_GRID) ? TB_MAX_GRID : int'(grid);
            if (n_eff == 0) begin
                repeat (6) send_cell(IDX_W'($urandom_range(0, 131071)));
            end else begin
                in_grid = 0;
                while (in_grid < per_setting) begin
                    // mostly real cells, some raw noise across all 17 bits
                    if ($urandom_range(0, 99) < 12)
                        cell_idx = IDX_W'($urandom_range(0, 131071));
                    else
                        cell_idx = IDX_W'($urandom_range(1, n_eff * n_eff));
                    if (cell_idx != 0 && cell_idx <= n_eff * n_eff) in_grid++;
                    send_cell(cell_idx);
                end
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_tiny_grids();
        test_radius_extremes();
        test_output_backpressure();
        test_paused_sender();
        test_random_traffic(17, 45, 5, 23);
        test_random_traffic(45, 17, 5, 23);
        test_random_traffic(0, 0, 5, 23);

        settle();
        if (ring_expected.size() != 0) begin
            mismatches = mismatches + 1;
            $display("ERROR: %0d expected beats never arrived", ring_expected.size());
        end
        $display("summary: %0d cell beats in, %0d ring beats checked, %0d mismatches",
                 cells_in, ring_beats, mismatches);
        $display("summary: %0d register settings, grids 0..511, radii 0..7, %0d cycles",
                 settings_used, cycle_cnt);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
